// ===== hw/rtl/olt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg
// Shared constants, command codes and controller/datapath interface types
// for the online FDR threshold core.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int unsigned GAMMA_DEPTH_DEF = 4096;
  localparam int unsigned MAX_REJECTS_DEF = 64;

  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  // Input item commands.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TEST  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Level modes.
  localparam logic [1:0] MODE_PLUS    = 2'd0;
  localparam logic [1:0] MODE_DISCARD = 2'd1;
  localparam logic [1:0] MODE_THREE   = 2'd2;
  localparam logic [1:0] MODE_DEP     = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_ALPHA   = 3'd1;
  localparam logic [2:0] REG_WEALTH  = 3'd2;
  localparam logic [2:0] REG_REWARD  = 3'd3;
  localparam logic [2:0] REG_DISCARD = 3'd4;

  localparam logic [31:0] ALPHA_RST   = 32'd107374182;
  localparam logic [31:0] WEALTH_RST  = 32'd10737418;
  localparam logic [31:0] REWARD_RST  = 32'd96636764;
  localparam logic [31:0] DISCARD_RST = 32'd1073741824;

  localparam logic signed [41:0] W_MAX = 42'sd549755813887;
  localparam logic signed [41:0] W_MIN = -42'sd549755813888;

  typedef struct packed {
    logic capture;
    logic write;
    logic clear;
    logic prep;
    logic issue;
    logic calc;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       last_term;
    logic       busy;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [31:0] sat_one(input logic [31:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/olt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/olt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ctrl
// Sequencer for the threshold core: decodes each item and steps the
// datapath through term issue, pipeline drain, level and state update.
// ----------------------------------------------------------------------------
module olt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire olt_pkg::dp_sts_t   sts,
  output olt_pkg::ctrl_cmd_t      ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREP,
    ST_ISSUE,
    ST_DRAIN,
    ST_CALC,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_DECODE;
        end
        ST_DECODE: begin
          if (sts.cmd == olt_pkg::CMD_TEST) state <= ST_PREP;
          else state <= ST_IDLE;
        end
        ST_PREP:  state <= ST_ISSUE;
        ST_ISSUE: begin
          if (sts.last_term) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!sts.busy) state <= ST_CALC;
        end
        ST_CALC:  state <= ST_FINISH;
        ST_FINISH: begin
          if (sts.out_free) state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    ctl.capture = (state == ST_IDLE) && in_valid;
    ctl.write   = (state == ST_DECODE) && (sts.cmd == olt_pkg::CMD_LOAD);
    ctl.clear   = (state == ST_DECODE) && (sts.cmd == olt_pkg::CMD_CLEAR);
    ctl.prep    = (state == ST_PREP);
    ctl.issue   = (state == ST_ISSUE);
    ctl.calc    = (state == ST_CALC);
    ctl.finish  = (state == ST_FINISH) && sts.out_free;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/olt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_dp
// Datapath: configuration registers, gamma table and rejection store,
// the term pipeline (store read, gamma read, multiply, accumulate), the
// level clamp, wealth update and the result register.
// ----------------------------------------------------------------------------
module olt_dp #(
  parameter int unsigned GAMMA_DEPTH = olt_pkg::GAMMA_DEPTH_DEF,
  parameter int unsigned MAX_REJECTS = olt_pkg::MAX_REJECTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire olt_pkg::ctrl_cmd_t ctl,
  output olt_pkg::dp_sts_t        sts,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         cmd,
  input  wire logic [11:0]        gamma_index,
  input  wire logic [31:0]        gamma_value,
  input  wire logic [31:0]        p_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             test_level,
  output logic                    reject,
  output logic                    history_full,
  output logic                    beyond_table
);

  localparam int unsigned GAW = $clog2(GAMMA_DEPTH);
  localparam int unsigned SAW = $clog2(MAX_REJECTS);
  localparam int unsigned RCW = $clog2(MAX_REJECTS + 1);

  // Configuration.
  logic [1:0]  mode;
  logic [31:0] alpha, w0, reward, dlev;

  // Captured item.
  logic [1:0]  cmd_r;
  logic [11:0] gidx_r;
  logic [31:0] gval_r, p_r;

  // History.
  logic [31:0]        test_count, selected_count, last_pos;
  logic [RCW-1:0]     reject_count;
  logic signed [39:0] wealth, walr;
  logic               started;

  // Per-test working registers.
  logic [31:0]        ta;
  logic [RCW-1:0]     term;
  logic               s1_vld, s1_base, s1_first;
  logic               s2_vld, s2_base, s2_first, s2_beyond;
  logic               s3_vld;
  logic signed [47:0] s3_val, acc;
  logic               beyond_r;
  logic [31:0]        level;

  // Memories.
  logic           g_we, s_we;
  logic [GAW-1:0] g_raddr;
  logic [31:0]    g_rdata;
  logic [63:0]    s_rdata, s_wdata;
  logic [31:0]    gidx;

  olt_ram #(.WIDTH(32), .DEPTH(GAMMA_DEPTH)) u_gamma (
    .clk   (clk),
    .we    (g_we),
    .waddr (GAW'(gidx_r)),
    .wdata (olt_pkg::sat_one(gval_r)),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  olt_ram #(.WIDTH(64), .DEPTH(MAX_REJECTS)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (SAW'(reject_count)),
    .wdata (s_wdata),
    .raddr (SAW'(term - RCW'(1))),
    .rdata (s_rdata)
  );

  assign g_we = ctl.write && (32'(gidx_r) < 32'(GAMMA_DEPTH));

  // Stage 1: gamma index from the stored rejection (or the base term).
  always_comb begin
    if (s1_base) begin
      unique case (mode)
        olt_pkg::MODE_DISCARD: gidx = selected_count;
        olt_pkg::MODE_THREE:   gidx = test_count - last_pos;
        default:               gidx = test_count;
      endcase
    end else if (mode == olt_pkg::MODE_DISCARD) begin
      gidx = selected_count - s_rdata[31:0];
    end else begin
      gidx = test_count - s_rdata[63:32] - 32'd1;
    end
    g_raddr = GAW'(gidx);
  end

  // Stage 2: gamma times coefficient, or gamma times wealth.
  logic [31:0]        g;
  logic signed [32:0] coef, cmain;
  logic               cneg;
  logic [31:0]        cmag;
  logic [63:0]        prod;
  logic signed [47:0] cterm;
  logic [39:0]        p_hi;
  logic [62:0]        p_lo;
  logic [47:0]        wterm;

  always_comb begin
    g     = s2_beyond ? 32'd0 : g_rdata;
    cmain = (mode == olt_pkg::MODE_DISCARD) ? $signed({1'b0, ta}) : $signed({1'b0, alpha});
    if (s2_base) coef = $signed({1'b0, w0});
    else if (s2_first) coef = cmain - $signed({1'b0, w0});
    else coef = cmain;
    cneg  = coef[32];
    cmag  = cneg ? 32'(-coef) : coef[31:0];
    prod  = 64'(g) * 64'(cmag);
    cterm = cneg ? -$signed({15'd0, prod[63:31]}) : $signed({15'd0, prod[63:31]});
    p_hi  = 40'(g) * 40'(walr[38:31]);
    p_lo  = 63'(g) * 63'(walr[30:0]);
    wterm = (walr > 40'sd0) ? (48'(p_hi) + 48'(p_lo[62:31])) : 48'd0;
  end

  // Level clamp.
  logic signed [47:0] a1;
  logic [31:0]        level_next;
  always_comb begin
    if ((mode == olt_pkg::MODE_DISCARD) && (acc > $signed({16'd0, dlev}))) begin
      a1 = $signed({16'd0, dlev});
    end else begin
      a1 = acc;
    end
    if (a1 < 48'sd0) level_next = 32'd0;
    else if (a1 > $signed({16'd0, olt_pkg::Q_ONE})) level_next = olt_pkg::Q_ONE;
    else level_next = a1[31:0];
  end

  // Decision and wealth update.
  logic               rej;
  logic [31:0]        sel_next;
  logic signed [41:0] wsum;
  logic signed [39:0] wealth_next;
  logic               room;
  always_comb begin
    rej      = (p_r <= level);
    sel_next = selected_count + ((p_r <= dlev) ? 32'd1 : 32'd0);
    wsum     = $signed({{2{wealth[39]}}, wealth}) - $signed({10'd0, level})
             + $signed({10'd0, (rej ? reward : 32'd0)});
    if (wsum > olt_pkg::W_MAX) wealth_next = olt_pkg::W_MAX[39:0];
    else if (wsum < olt_pkg::W_MIN) wealth_next = olt_pkg::W_MIN[39:0];
    else wealth_next = wsum[39:0];
    room     = reject_count < RCW'(MAX_REJECTS);
  end

  assign s_we    = ctl.finish && rej && room;
  assign s_wdata = {test_count, sel_next};

  always_comb begin
    sts.cmd       = cmd_r;
    sts.last_term = (term == ((mode < olt_pkg::MODE_THREE) ? reject_count : RCW'(0)));
    sts.busy      = s1_vld || s2_vld || s3_vld;
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= olt_pkg::MODE_PLUS;
      alpha          <= olt_pkg::ALPHA_RST;
      w0             <= olt_pkg::WEALTH_RST;
      reward         <= olt_pkg::REWARD_RST;
      dlev           <= olt_pkg::DISCARD_RST;
      test_count     <= '0;
      selected_count <= '0;
      last_pos       <= '0;
      reject_count   <= '0;
      started        <= 1'b0;
      s1_vld         <= 1'b0;
      s2_vld         <= 1'b0;
      s3_vld         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          olt_pkg::REG_MODE:    mode   <= cfg_data[1:0];
          olt_pkg::REG_ALPHA:   alpha  <= olt_pkg::sat_one(cfg_data);
          olt_pkg::REG_WEALTH:  w0     <= olt_pkg::sat_one(cfg_data);
          olt_pkg::REG_REWARD:  reward <= olt_pkg::sat_one(cfg_data);
          olt_pkg::REG_DISCARD: dlev   <= olt_pkg::sat_one(cfg_data);
          default: ;
        endcase
      end

      if (ctl.clear) begin
        test_count     <= '0;
        selected_count <= '0;
        last_pos       <= '0;
        reject_count   <= '0;
        started        <= 1'b0;
      end

      // Wealth is loaded from the register at the first test of a stream.
      if (ctl.prep && !started) begin
        wealth  <= $signed({8'd0, w0});
        walr    <= $signed({8'd0, w0});
        started <= 1'b1;
      end

      s1_vld <= ctl.issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;

      if (ctl.finish) begin
        test_count     <= test_count + 32'd1;
        selected_count <= sel_next;
        wealth         <= wealth_next;
        if (rej) begin
          last_pos <= test_count + 32'd1;
          walr     <= wealth_next;
          if (room) reject_count <= reject_count + RCW'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd;
      gidx_r <= gamma_index;
      gval_r <= gamma_value;
      p_r    <= p_value;
    end
    if (ctl.prep) begin
      ta       <= 32'((64'(dlev) * 64'(alpha)) >> 31);
      term     <= '0;
      acc      <= '0;
      beyond_r <= 1'b0;
    end
    if (ctl.issue) begin
      term     <= term + RCW'(1);
      s1_base  <= (term == RCW'(0));
      s1_first <= (term == RCW'(1));
    end
    s2_base   <= s1_base;
    s2_first  <= s1_first;
    s2_beyond <= (gidx >= 32'(GAMMA_DEPTH));
    s3_val    <= (mode >= olt_pkg::MODE_THREE) ? $signed(wterm) : cterm;
    if (s2_vld && s2_beyond) beyond_r <= 1'b1;
    if (s3_vld) acc <= acc + s3_val;
    if (ctl.calc) level <= level_next;
    if (ctl.finish) begin
      test_level   <= level;
      reject       <= rej;
      history_full <= rej && !room;
      beyond_table <= beyond_r;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/online_fdr_lord_threshold_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// online_fdr_lord_threshold_core
// Online FDR test-level generator of the LORD family with gamma table load.
// ----------------------------------------------------------------------------
// One item is handled at a time. A gamma load or a history clear is
// captured and then applied in the decode state. A test issues one term
// for the base and one per stored rejection in modes 0 and 1, where at
// most MAX_REJECTS rejections are stored, and a single term in modes 2
// and 3. The rejection store is read one entry per cycle and each entry
// flows through a gamma table read, one multiply and the accumulator;
// the pipeline then drains before the level is formed. The next item is
// accepted once the result is in the output register.
// A finished result sits in an output register, so the next item is taken
// while it waits. Configuration writes are accepted in every cycle and must
// only be issued while no item is in progress.
module online_fdr_lord_threshold_core #(
  parameter int unsigned GAMMA_DEPTH = olt_pkg::GAMMA_DEPTH_DEF,
  parameter int unsigned MAX_REJECTS = olt_pkg::MAX_REJECTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [11:0] gamma_index,
  input  wire logic [31:0] gamma_value,
  input  wire logic [31:0] p_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      test_level,
  output logic             reject,
  output logic             history_full,
  output logic             beyond_table,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  olt_pkg::ctrl_cmd_t ctl;
  olt_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  olt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  olt_dp #(
    .GAMMA_DEPTH (GAMMA_DEPTH),
    .MAX_REJECTS (MAX_REJECTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .gamma_index  (gamma_index),
    .gamma_value  (gamma_value),
    .p_value      (p_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .test_level   (test_level),
    .reject       (reject),
    .history_full (history_full),
    .beyond_table (beyond_table)
  );

endmodule
`default_nettype wire

// ===== sim/online_fdr_lord_threshold_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// online_fdr_lord_threshold_core_tb
// Self-checking bench for the LORD-family online FDR core. A gamma table is
// loaded, p-value streams are run in all four modes under random stalls on
// both sides, and every level and flag is compared with an in-bench
// predictor of levels, rejections, stored history and wealth.
// ----------------------------------------------------------------------------
module online_fdr_lord_threshold_core_tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned DEPTH = olt_pkg::GAMMA_DEPTH_DEF;
  localparam int unsigned NREJ = olt_pkg::MAX_REJECTS_DEF;
  localparam int unsigned TABLE_USED = 160;
  localparam longint WEALTH_HI = 64'sd549755813887;
  localparam longint WEALTH_LO = -64'sd549755813888;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [31:0] level;
    logic        rej;
    logic        full;
    logic        oob;
  } level_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [11:0] gamma_index;
  logic [31:0] gamma_value;
  logic [31:0] p_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] test_level;
  logic        reject;
  logic        history_full;
  logic        beyond_table;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  online_fdr_lord_threshold_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .gamma_index(gamma_index), .gamma_value(gamma_value), .p_value(p_value),
    .out_valid(out_valid), .out_ready(out_ready), .test_level(test_level),
    .reject(reject), .history_full(history_full), .beyond_table(beyond_table),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [31:0]   gamma_mem [0:DEPTH-1];
  logic [31:0]   hist_time [0:NREJ-1];
  logic [31:0]   hist_sel [0:NREJ-1];
  logic [31:0]   n_tests, n_sel, last_rej_pos;
  int unsigned   n_rej;
  longint        wealth_now, wealth_rej;
  bit            stream_live;
  logic [1:0]    m_mode;
  logic [31:0]   m_alpha, m_w0, m_reward, m_tau;

  level_result_t expected_levels[$];
  int            err_count = 0;
  int unsigned   cycles = 0;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b1;
  int            hold_cycles = 0;
  int            rx_wait;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("online_fdr_lord_threshold_core verification failed");
      $finish;
    end
  end

  // Receiver: random stall per result, plus an optional long hold-off.
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (out_valid && out_ready && rx_idle) begin
      gap = $urandom_range(0, 16);
      out_ready <= (gap == 0);
      rx_wait <= (gap > 0) ? gap - 1 : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    level_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("result with no expectation: test_level %h", test_level);
        err_count++;
      end else begin
        e = expected_levels.pop_front();
        if (test_level !== e.level) begin
          $error("test_level expected %h actual %h", e.level, test_level);
          err_count++;
        end
        if (reject !== e.rej) begin
          $error("reject expected %b actual %b", e.rej, reject);
          err_count++;
        end
        if (history_full !== e.full) begin
          $error("history_full expected %b actual %b", e.full, history_full);
          err_count++;
        end
        if (beyond_table !== e.oob) begin
          $error("beyond_table expected %b actual %b", e.oob, beyond_table);
          err_count++;
        end
      end
    end
  end

  function automatic logic [31:0] clamp_one(input logic [31:0] v);
    return (v > olt_pkg::Q_ONE) ? olt_pkg::Q_ONE : v;
  endfunction

  function automatic longint coef_product(input longint unsigned g, input longint c);
    longint unsigned mag;
    if (c < 0) begin
      mag = (g * longint'(-c)) >> 31;
      return -longint'(mag);
    end
    mag = (g * c) >> 31;
    return longint'(mag);
  endfunction

  function automatic longint wealth_product(input longint unsigned g, input longint w);
    longint unsigned uw;
    if (w <= 0) return 0;
    uw = w;
    return longint'(g * (uw >> 31) + ((g * (uw & 64'h7FFF_FFFF)) >> 31));
  endfunction

  function automatic longint wealth_clip(input longint v);
    if (v > WEALTH_HI) return WEALTH_HI;
    if (v < WEALTH_LO) return WEALTH_LO;
    return v;
  endfunction

  function automatic longint unsigned gamma_read(input logic [31:0] idx, inout bit oob);
    if (idx >= DEPTH) begin
      oob = 1'b1;
      return 0;
    end
    return {32'd0, gamma_mem[idx]};
  endfunction

  task automatic restart_history();
    n_tests = 0;
    n_rej = 0;
    n_sel = 0;
    last_rej_pos = 0;
    wealth_now = m_w0;
    wealth_rej = m_w0;
    stream_live = 1'b0;
  endtask

  // Works out the level and flags of one test and advances the history.
  task automatic predict_level(input logic [31:0] pv);
    level_result_t r;
    longint acc, ta, lvl;
    bit oob;
    bit rej;
    int unsigned j;
    if (!stream_live) begin
      wealth_now = m_w0;
      wealth_rej = m_w0;
      stream_live = 1'b1;
    end
    oob = 1'b0;
    r.full = 1'b0;
    case (m_mode)
      olt_pkg::MODE_PLUS: begin
        acc = coef_product(gamma_read(n_tests, oob), longint'(m_w0));
        for (j = 0; j < n_rej; j++)
          acc += coef_product(gamma_read(n_tests - hist_time[j] - 32'd1, oob),
                              j == 0 ? longint'(m_alpha) - longint'(m_w0)
                                     : longint'(m_alpha));
      end
      olt_pkg::MODE_DISCARD: begin
        ta = longint'(({32'd0, m_tau} * {32'd0, m_alpha}) >> 31);
        acc = coef_product(gamma_read(n_sel, oob), longint'(m_w0));
        for (j = 0; j < n_rej; j++)
          acc += coef_product(gamma_read(n_sel - hist_sel[j], oob),
                              j == 0 ? ta - longint'(m_w0) : ta);
        if (acc > longint'(m_tau)) acc = m_tau;
      end
      olt_pkg::MODE_THREE: begin
        acc = wealth_product(gamma_read(n_tests - last_rej_pos, oob), wealth_rej);
      end
      default: acc = wealth_product(gamma_read(n_tests, oob), wealth_rej);
    endcase
    lvl = (acc < 0) ? 0 : ((acc > longint'(olt_pkg::Q_ONE)) ? longint'(olt_pkg::Q_ONE)
                                                              : acc);
    rej = longint'(pv) <= lvl;
    if (pv <= m_tau) n_sel++;
    wealth_now = wealth_clip(wealth_now - lvl + (rej ? longint'(m_reward) : 0));
    if (rej) begin
      if (n_rej < NREJ) begin
        hist_time[n_rej] = n_tests;
        hist_sel[n_rej] = n_sel;
        n_rej++;
      end else begin
        r.full = 1'b1;
      end
      last_rej_pos = n_tests + 32'd1;
      wealth_rej = wealth_now;
    end
    n_tests++;
    r.level = lvl[31:0];
    r.rej = rej;
    r.oob = oob;
    expected_levels.insert(expected_levels.size(), r);
  endtask

  task automatic send_item(input logic [1:0] c, input logic [11:0] idx,
                           input logic [31:0] gv, input logic [31:0] pv);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    gamma_index <= idx;
    gamma_value <= gv;
    p_value <= pv;
    do @(posedge clk); while (!in_ready);
    case (c)
      olt_pkg::CMD_LOAD:  gamma_mem[idx] = clamp_one(gv);
      olt_pkg::CMD_CLEAR: restart_history();
      olt_pkg::CMD_TEST:  predict_level(pv);
      default: ;
    endcase
  endtask

  task automatic run_test(input logic [31:0] pv);
    send_item(olt_pkg::CMD_TEST, 12'($urandom), $urandom, pv);
  endtask

  // Waits until every result is back and any load or clear has finished.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Register writes are made only while no item is in progress.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      olt_pkg::REG_MODE:    m_mode = data[1:0];
      olt_pkg::REG_ALPHA:   m_alpha = clamp_one(data);
      olt_pkg::REG_WEALTH:  m_w0 = clamp_one(data);
      olt_pkg::REG_REWARD:  m_reward = clamp_one(data);
      olt_pkg::REG_DISCARD: m_tau = clamp_one(data);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return olt_pkg::Q_ONE;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 32'h0800_0000);
      default: return $urandom_range(0, olt_pkg::Q_ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_p();
    case ($urandom_range(0, 9))
      0, 1:    return 32'd0;
      2, 3, 4: return $urandom_range(0, 32'h0100_0000);
      5, 6:    return $urandom_range(0, olt_pkg::Q_ONE);
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_table(input int unsigned lo, input int unsigned hi,
                            input bit fixed, input logic [31:0] v);
    int unsigned k;
    for (k = lo; k <= hi; k++)
      send_item(olt_pkg::CMD_LOAD, k[11:0],
                fixed ? v : (($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 32'h0800_0000)),
                $urandom);
  endtask

  // Only the low part of the table is loaded; no run between clears is long
  // enough to read past it.
  task automatic test_table_load();
    tx_idle = 1'b0;
    fill_table(0, TABLE_USED - 1, 1'b0, 32'd0);
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    send_item(CMD_NONE, 12'hFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(olt_pkg::CMD_LOAD, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(olt_pkg::CMD_LOAD, 12'd0, olt_pkg::Q_ONE, 32'd0);
    run_test(32'd0);
    run_test(olt_pkg::Q_ONE);
    run_test(32'hFFFF_FFFF);
    run_test(32'd1);
    send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
    run_test(32'd0);
    for (int md = 0; md < 4; md++) begin
      wait_idle();
      write_reg(olt_pkg::REG_MODE, md[1:0]);
      write_reg(olt_pkg::REG_ALPHA, 32'hFFFF_FFFF);
      write_reg(olt_pkg::REG_WEALTH, md[0] ? 32'd0 : olt_pkg::Q_ONE);
      write_reg(olt_pkg::REG_REWARD, md[1] ? olt_pkg::Q_ONE : 32'd0);
      write_reg(olt_pkg::REG_DISCARD, md[0] ? 32'hFFFF_FFFF : 32'd0);
      send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
      run_test(32'd0);
      run_test(pick_p());
      run_test(olt_pkg::Q_ONE);
    end
  endtask

  // Long runs of sure rejections fill the store, and in the dependent mode
  // the wealth grows well past one.
  task automatic test_store_and_wealth();
    tx_idle = 1'b0;
    wait_idle();
    write_reg(olt_pkg::REG_MODE, olt_pkg::MODE_PLUS);
    write_reg(olt_pkg::REG_ALPHA, olt_pkg::Q_ONE);
    write_reg(olt_pkg::REG_WEALTH, olt_pkg::Q_ONE);
    write_reg(olt_pkg::REG_REWARD, 32'd0);
    write_reg(olt_pkg::REG_DISCARD, olt_pkg::Q_ONE);
    send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
    repeat (70) run_test(32'd0);
    wait_idle();
    write_reg(olt_pkg::REG_MODE, olt_pkg::MODE_DISCARD);
    send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
    repeat (70) run_test(32'd0);
    wait_idle();
    write_reg(olt_pkg::REG_MODE, olt_pkg::MODE_DEP);
    write_reg(olt_pkg::REG_REWARD, olt_pkg::Q_ONE);
    send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
    repeat (30) run_test(32'd0);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    wait_idle();
    write_reg(olt_pkg::REG_MODE, olt_pkg::MODE_THREE);
    write_reg(olt_pkg::REG_WEALTH, olt_pkg::WEALTH_RST);
    write_reg(olt_pkg::REG_REWARD, olt_pkg::REWARD_RST);
    write_reg(olt_pkg::REG_ALPHA, olt_pkg::ALPHA_RST);
    write_reg(olt_pkg::REG_DISCARD, olt_pkg::DISCARD_RST);
    send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
    hold_cycles = 400;
    repeat (20) run_test(pick_p());
  endtask

  task automatic test_random();
    int unsigned sel;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      tx_idle = (ph != 2);
      rx_idle = (ph != 3);
      write_reg(olt_pkg::REG_MODE, $urandom_range(0, 3));
      write_reg(olt_pkg::REG_ALPHA, pick_fraction());
      write_reg(olt_pkg::REG_WEALTH, pick_fraction());
      write_reg(olt_pkg::REG_REWARD, pick_fraction());
      write_reg(olt_pkg::REG_DISCARD, pick_fraction());
      send_item(olt_pkg::CMD_CLEAR, 12'd0, 32'd0, 32'd0);
      repeat (45) begin
        sel = $urandom_range(0, 99);
        if (sel < 82)      run_test(pick_p());
        else if (sel < 92) send_item(olt_pkg::CMD_LOAD, 12'($urandom),
                                     $urandom_range(0, 32'h0800_0000), $urandom);
        else if (sel < 96) send_item(olt_pkg::CMD_CLEAR, 12'($urandom), $urandom, $urandom);
        else               send_item(CMD_NONE, 12'($urandom), $urandom, $urandom);
      end
    end
    rx_idle = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = olt_pkg::CMD_LOAD;
    gamma_index = '0;
    gamma_value = '0;
    p_value = '0;
    cfg_valid = 1'b0;
    cfg_index = olt_pkg::REG_MODE;
    cfg_data = '0;
    m_mode = olt_pkg::MODE_PLUS;
    m_alpha = olt_pkg::ALPHA_RST;
    m_w0 = olt_pkg::WEALTH_RST;
    m_reward = olt_pkg::REWARD_RST;
    m_tau = olt_pkg::DISCARD_RST;
    restart_history();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_store_and_wealth();
    test_backpressure();
    test_random();
    wait_idle();
    if (err_count == 0)
      $display("online_fdr_lord_threshold_core verification clean");
    else
      $display("online_fdr_lord_threshold_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/olt_pkg.sv
hw/rtl/olt_ram.sv
hw/rtl/olt_ctrl.sv
hw/rtl/olt_dp.sv
hw/rtl/online_fdr_lord_threshold_core.sv
sim/online_fdr_lord_threshold_core_tb.sv
